// ----- src/slc_pkg.sv -----
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types, constants and helpers for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int unsigned MAX_SET_INDEX_BITS_DEF = 6;
  localparam int unsigned MAX_WAYS_DEF           = 8;

  localparam int unsigned AGE_W     = 32;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAY_COUNT         = 2'd2;

  localparam logic [1:0] OP_MODIFY = 2'd2;

  localparam logic [CNT_W-1:0] SAT_MAX = '1;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SEARCH,
    ST_WRITE
  } back_state_e;

  typedef struct packed {
    logic [2:0] set_index_bits;
    logic [5:0] block_offset_bits;
    logic [3:0] way_count;
  } cfg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == SAT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ----- src/set_associative_lru_cache_sim.sv -----
// ----------------------------------------------------------------------------
// set_associative_lru_cache_sim
// Trace-driven set-associative cache with LRU replacement and hit/miss/evict
// counters.
// ----------------------------------------------------------------------------
// After reset the age and tag memories are swept, one set per cycle, over all
// 2**MAX_SET_INDEX_BITS sets (64 by default) with in_stall_o high; config
// writes are taken during the sweep. Each access then goes through set read,
// compare and age, and write back to the set memory on a hit or a fill; on an
// eviction a victim search over the ways in use (way_count, clamped to
// 1..MAX_WAYS) comes before the write back, and finds the oldest way one way per
// cycle. A two-entry queue takes new words while the engine works, and a
// finished result waits in the output register.
module set_associative_lru_cache_sim import slc_pkg::*; #(
  parameter int unsigned MAX_SET_INDEX_BITS = MAX_SET_INDEX_BITS_DEF,
  parameter int unsigned MAX_WAYS           = MAX_WAYS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [ADDR_W-1:0]    address_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           outcome_o,
  output logic                 extra_hit_o,
  output logic [CNT_W-1:0]     hit_total_o,
  output logic [CNT_W-1:0]     miss_total_o,
  output logic [CNT_W-1:0]     evict_total_o
);

  localparam int unsigned SA_W = (MAX_SET_INDEX_BITS > 0) ? MAX_SET_INDEX_BITS : 1;
  localparam int unsigned QW   = SA_W + TAG_W + 1;

  cfg_t             cfg;
  logic             clearing;
  logic             q_full, q_empty, push, pop;
  logic [SA_W-1:0]  push_set, q_set;
  logic [TAG_W-1:0] push_tag, q_tag;
  logic             push_mod, q_mod;
  logic [QW-1:0]    q_rdata;

  slc_front #(
    .MAX_SET_INDEX_BITS(MAX_SET_INDEX_BITS),
    .SA_W              (SA_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .address_i  (address_i),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_set_o (push_set),
    .push_tag_o (push_tag),
    .push_mod_o (push_mod)
  );

  slc_queue #(
    .W(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({push_set, push_tag, push_mod}),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .rdata_o(q_rdata)
  );

  assign {q_set, q_tag, q_mod} = q_rdata;

  slc_back #(
    .MAX_SET_INDEX_BITS(MAX_SET_INDEX_BITS),
    .MAX_WAYS          (MAX_WAYS),
    .SA_W              (SA_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_empty_i    (q_empty),
    .q_set_i      (q_set),
    .q_tag_i      (q_tag),
    .q_mod_i      (q_mod),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .outcome_o    (outcome_o),
    .extra_hit_o  (extra_hit_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o),
    .evict_total_o(evict_total_o)
  );

endmodule

// ----- src/slc_front.sv -----
// ----------------------------------------------------------------------------
// slc_front
// Config registers and request intake: splits each address into set and tag.
// ----------------------------------------------------------------------------
module slc_front import slc_pkg::*; #(
  parameter int unsigned MAX_SET_INDEX_BITS = MAX_SET_INDEX_BITS_DEF,
  parameter int unsigned SA_W = (MAX_SET_INDEX_BITS > 0) ? MAX_SET_INDEX_BITS : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output cfg_t                 cfg_o,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic                 clearing_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output logic [SA_W-1:0]      push_set_o,
  output logic [TAG_W-1:0]     push_tag_o,
  output logic                 push_mod_o
);

  cfg_t              cfg_q;
  logic [3:0]        sbits;
  logic [6:0]        shift;
  logic [ADDR_W-1:0] tag_shifted;
  logic [ADDR_W-1:0] set_shifted;
  logic [SA_W-1:0]   set_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_index_bits    <= 3'd0;
      cfg_q.block_offset_bits <= 6'd0;
      cfg_q.way_count         <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SET_INDEX_BITS:    cfg_q.set_index_bits    <= cfg_wdata_i[2:0];
        REG_BLOCK_OFFSET_BITS: cfg_q.block_offset_bits <= cfg_wdata_i;
        REG_WAY_COUNT:         cfg_q.way_count         <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

  always_comb begin
    if (int'(cfg_q.set_index_bits) > int'(MAX_SET_INDEX_BITS)) begin
      sbits = 4'(MAX_SET_INDEX_BITS);
    end else begin
      sbits = {1'b0, cfg_q.set_index_bits};
    end
    shift       = 7'(cfg_q.block_offset_bits) + 7'(sbits);
    tag_shifted = address_i >> shift[5:0];
    set_shifted = address_i >> cfg_q.block_offset_bits;
    for (int i = 0; i < int'(SA_W); i++) begin
      set_mask[i] = (i < int'(sbits));
    end
  end

  assign push_tag_o = shift[6] ? '0 : tag_shifted[TAG_W-1:0];
  assign push_set_o = set_shifted[SA_W-1:0] & set_mask;
  assign push_mod_o = (opcode_i == OP_MODIFY);
  assign in_stall_o = q_full_i | clearing_i;
  assign push_o     = in_valid_i & ~in_stall_o;

endmodule

// ----- src/slc_queue.sv -----
// ----------------------------------------------------------------------------
// slc_queue
// Two-entry request queue between intake and the cache engine.
// ----------------------------------------------------------------------------
module slc_queue import slc_pkg::*; #(
  parameter int unsigned W = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] rdata_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- src/slc_back.sv -----
// ----------------------------------------------------------------------------
// slc_back
// Cache engine: set read, way compare and aging, victim search, write back.
// ----------------------------------------------------------------------------
module slc_back import slc_pkg::*; #(
  parameter int unsigned MAX_SET_INDEX_BITS = MAX_SET_INDEX_BITS_DEF,
  parameter int unsigned MAX_WAYS           = MAX_WAYS_DEF,
  parameter int unsigned SA_W = (MAX_SET_INDEX_BITS > 0) ? MAX_SET_INDEX_BITS : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             q_empty_i,
  input  logic [SA_W-1:0]  q_set_i,
  input  logic [TAG_W-1:0] q_tag_i,
  input  logic             q_mod_i,
  output logic             pop_o,
  output logic             clearing_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       outcome_o,
  output logic             extra_hit_o,
  output logic [CNT_W-1:0] hit_total_o,
  output logic [CNT_W-1:0] miss_total_o,
  output logic [CNT_W-1:0] evict_total_o
);

  localparam int unsigned SETS  = 1 << MAX_SET_INDEX_BITS;
  localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WC_W  = $clog2(MAX_WAYS + 1);

  typedef logic [MAX_WAYS-1:0][AGE_W-1:0] age_row_t;
  typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;

  age_row_t age_mem [SETS];
  tag_row_t tag_mem [SETS];

  back_state_e      state_q, state_d;
  logic [SA_W-1:0]  clr_q, clr_d;
  logic [SA_W-1:0]  req_set_q;
  logic [TAG_W-1:0] req_tag_q;
  logic             req_mod_q;
  age_row_t         age_rd_q, age_row_q, age_row_d;
  tag_row_t         tag_rd_q, tag_row_q, tag_row_d;
  outcome_e         outcome_q, outcome_d;
  logic [WAY_W-1:0] victim_q, victim_d;
  logic [WC_W-1:0]  srch_q, srch_d;
  logic [CNT_W-1:0] hit_q, hit_d, miss_q, miss_d, evict_q, evict_d;
  logic [CNT_W-1:0] hit_once;
  logic             out_valid_q, out_valid_d;
  outcome_e         out_outcome_q;
  logic             out_extra_q;
  logic             out_load;

  logic             mem_we, mem_re;
  logic [SA_W-1:0]  mem_addr;

  logic [WC_W-1:0]     ways;
  logic [MAX_WAYS-1:0] in_use, valid, match, empty;
  logic                hit, any_empty;
  logic [WAY_W-1:0]    first_empty;
  age_row_t            eval_age;
  tag_row_t            eval_tag;

  always_comb begin
    if (cfg_i.way_count == 4'd0) begin
      ways = WC_W'(1);
    end else if (int'(cfg_i.way_count) > int'(MAX_WAYS)) begin
      ways = WC_W'(MAX_WAYS);
    end else begin
      ways = WC_W'(cfg_i.way_count);
    end
  end

  // way compare and aging on the row just read
  always_comb begin
    eval_age    = age_rd_q;
    eval_tag    = tag_rd_q;
    first_empty = '0;
    for (int w = 0; w < int'(MAX_WAYS); w++) begin
      in_use[w] = (w < int'(ways));
      valid[w]  = (age_rd_q[w] != '0);
      match[w]  = in_use[w] & valid[w] & (tag_rd_q[w] == req_tag_q);
      empty[w]  = in_use[w] & ~valid[w];
      if (match[w]) begin
        eval_age[w] = AGE_W'(1);
      end else if (in_use[w] && valid[w]) begin
        eval_age[w] = sat_inc(age_rd_q[w]);
      end
    end
    for (int w = int'(MAX_WAYS) - 1; w >= 0; w--) begin
      if (empty[w]) begin
        first_empty = WAY_W'(w);
      end
    end
    hit       = |match;
    any_empty = |empty;
    if (!hit && any_empty) begin
      eval_age[first_empty] = AGE_W'(1);
      eval_tag[first_empty] = req_tag_q;
    end
  end

  always_comb begin
    hit_once = (outcome_q == OUT_HIT) ? sat_inc(hit_q) : hit_q;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    age_row_d   = age_row_q;
    tag_row_d   = tag_row_q;
    outcome_d   = outcome_q;
    victim_d    = victim_q;
    srch_d      = srch_q;
    hit_d       = hit_q;
    miss_d      = miss_q;
    evict_d     = evict_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q & out_stall_i;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    pop_o       = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + SA_W'(1);
        if (clr_q == SA_W'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          mem_re  = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        age_row_d = eval_age;
        tag_row_d = eval_tag;
        if (hit) begin
          outcome_d = OUT_HIT;
          state_d   = ST_WRITE;
        end else if (any_empty) begin
          outcome_d = OUT_FILL;
          state_d   = ST_WRITE;
        end else begin
          outcome_d = OUT_EVICT;
          victim_d  = '0;
          srch_d    = WC_W'(1);
          state_d   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (srch_q >= ways) begin
          age_row_d[victim_q] = AGE_W'(1);
          tag_row_d[victim_q] = req_tag_q;
          state_d             = ST_WRITE;
        end else begin
          if (age_row_q[srch_q[WAY_W-1:0]] > age_row_q[victim_q]) begin
            victim_d = srch_q[WAY_W-1:0];
          end
          srch_d = srch_q + WC_W'(1);
        end
      end
      ST_WRITE: begin
        if (!out_valid_q || !out_stall_i) begin
          mem_we      = 1'b1;
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          hit_d       = req_mod_q ? sat_inc(hit_once) : hit_once;
          if (outcome_q != OUT_HIT) begin
            miss_d = sat_inc(miss_q);
          end
          if (outcome_q == OUT_EVICT) begin
            evict_d = sat_inc(evict_q);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign clearing_o = (state_q == ST_CLEAR);
  assign mem_addr   = clearing_o ? clr_q : req_set_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      age_mem[mem_addr] <= clearing_o ? '0 : age_row_q;
      tag_mem[mem_addr] <= clearing_o ? '0 : tag_row_q;
    end
    if (mem_re) begin
      age_rd_q <= age_mem[q_set_i];
      tag_rd_q <= tag_mem[q_set_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      hit_q       <= '0;
      miss_q      <= '0;
      evict_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hit_q       <= hit_d;
      miss_q      <= miss_d;
      evict_q     <= evict_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      req_set_q <= q_set_i;
      req_tag_q <= q_tag_i;
      req_mod_q <= q_mod_i;
    end
    age_row_q <= age_row_d;
    tag_row_q <= tag_row_d;
    outcome_q <= outcome_d;
    victim_q  <= victim_d;
    srch_q    <= srch_d;
    if (out_load) begin
      out_outcome_q <= outcome_q;
      out_extra_q   <= req_mod_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = out_outcome_q;
  assign extra_hit_o   = out_extra_q;
  assign hit_total_o   = hit_q;
  assign miss_total_o  = miss_q;
  assign evict_total_o = evict_q;

endmodule

// ----- src/slc_checker.sv -----
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks on the result channel and running counters.
// ----------------------------------------------------------------------------
module slc_checker import slc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_stall_i,
  input logic [1:0]       outcome_i,
  input logic             extra_hit_i,
  input logic [CNT_W-1:0] hit_total_i,
  input logic [CNT_W-1:0] miss_total_i,
  input logic [CNT_W-1:0] evict_total_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_hit_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> hit_total_i >= $past(hit_total_i))
    else $error("hit total went down");

  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (outcome_i != OUT_HIT) |-> miss_total_i != '0)
    else $error("miss reported with zero miss total");

  a_evict_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (outcome_i == OUT_EVICT) |-> evict_total_i != '0)
    else $error("eviction reported with zero eviction total");

  a_extra_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && extra_hit_i |-> hit_total_i != '0)
    else $error("extra hit reported with zero hit total");

endmodule

bind set_associative_lru_cache_sim slc_checker u_slc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .outcome_i    (outcome_o),
  .extra_hit_i  (extra_hit_o),
  .hit_total_i  (hit_total_o),
  .miss_total_i (miss_total_o),
  .evict_total_i(evict_total_o)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative LRU cache. A queue-fed driver
// offers access words and predicts each outcome and running total as the word
// is taken. A monitor compares every result word with the oldest prediction.
// Directed accesses come first: field extremes, every opcode, saturated
// register values, long shifts and duplicate tags. Random phases follow, each
// with its own register setting, and both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import slc_pkg::*;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_ODD   = 2'd3;

  localparam int SETS          = 1 << MAX_SET_INDEX_BITS_DEF;
  localparam int LINES         = SETS * MAX_WAYS_DEF;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
  } access_t;

  typedef struct packed {
    outcome_e          outcome;
    logic              extra_hit;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  misses;
    logic [CNT_W-1:0]  evicts;
  } result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           opcode_i    = '0;
  logic [ADDR_W-1:0]    address_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           outcome_o;
  logic                 extra_hit_o;
  logic [CNT_W-1:0]     hit_total_o;
  logic [CNT_W-1:0]     miss_total_o;
  logic [CNT_W-1:0]     evict_total_o;

  set_associative_lru_cache_sim dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .outcome_o    (outcome_o),
    .extra_hit_o  (extra_hit_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o),
    .evict_total_o(evict_total_o)
  );

  // cache shadow
  cfg_t             cfg_m;
  logic [TAG_W-1:0] tag_m [LINES];
  logic [AGE_W-1:0] age_m [LINES];
  logic [CNT_W-1:0] hits_m, misses_m, evicts_m;

  access_t pending_q [$];
  result_t expected_q [$];
  access_t next_word;

  int gap_pct   = 19;
  int hold_ask  = 0;
  int hold_done = 0;
  int hold_left = 0;
  int cycles    = 0;
  int errors    = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_configs = 0;
  int n_hit_out = 0;
  int n_fill    = 0;
  int n_evict   = 0;
  int n_modify  = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic void predict_access(input access_t a);
    int unsigned sb, nw, sh, base, victim, w, i;
    logic [TAG_W-1:0] tg;
    logic [63:0]      setv;
    logic             hit, filled;
    result_t          r;
    sb = (cfg_m.set_index_bits > MAX_SET_INDEX_BITS_DEF) ? MAX_SET_INDEX_BITS_DEF
                                                          : cfg_m.set_index_bits;
    nw = cfg_m.way_count;
    if (nw < 1) nw = 1;
    if (nw > MAX_WAYS_DEF) nw = MAX_WAYS_DEF;
    sh = cfg_m.block_offset_bits + sb;
    tg = (sh >= 64) ? '0 : TAG_W'(a.address >> sh);
    setv = (a.address >> cfg_m.block_offset_bits) & ((64'd1 << sb) - 64'd1);
    base = int'(setv) * MAX_WAYS_DEF;
    hit = 1'b0;
    for (w = 0; w < nw; w++) begin
      i = base + w;
      if (age_m[i] != '0) begin
        if (tag_m[i] == tg) begin
          age_m[i] = 32'd1;
          hit = 1'b1;
        end else begin
          age_m[i] = bump(age_m[i]);
        end
      end
    end
    if (hit) begin
      r.outcome = OUT_HIT;
      hits_m = bump(hits_m);
      n_hit_out++;
    end else begin
      misses_m = bump(misses_m);
      filled = 1'b0;
      for (w = 0; w < nw && !filled; w++) begin
        i = base + w;
        if (age_m[i] == '0) begin
          tag_m[i] = tg;
          age_m[i] = 32'd1;
          filled = 1'b1;
        end
      end
      if (filled) begin
        r.outcome = OUT_FILL;
        n_fill++;
      end else begin
        victim = 0;
        for (w = 1; w < nw; w++) begin
          if (age_m[base + w] > age_m[base + victim]) victim = w;
        end
        tag_m[base + victim] = tg;
        age_m[base + victim] = 32'd1;
        evicts_m = bump(evicts_m);
        r.outcome = OUT_EVICT;
        n_evict++;
      end
    end
    if (a.opcode == OP_MODIFY) begin
      hits_m = bump(hits_m);
      n_modify++;
    end
    r.extra_hit = (a.opcode == OP_MODIFY);
    r.hits      = hits_m;
    r.misses    = misses_m;
    r.evicts    = evicts_m;
    expected_q.push_back(r);
  endfunction

  task automatic check_result();
    result_t want;
    logic    bad;
    n_checked++;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result word %0d arrived with none expected (outcome %0d)",
                                 n_checked, outcome_o);
    end else begin
      want = expected_q.pop_front();
      bad = (outcome_o !== want.outcome) || (extra_hit_o !== want.extra_hit) ||
            (hit_total_o !== want.hits) || (miss_total_o !== want.misses) ||
            (evict_total_o !== want.evicts);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch on result word %0d (expected / actual):", n_checked);
          $display("  outcome %0d / %0d  extra_hit %0b / %0b", want.outcome, outcome_o,
                   want.extra_hit, extra_hit_o);
          $display("  hits %0d / %0d  misses %0d / %0d  evicts %0d / %0d",
                   want.hits, hit_total_o, want.misses, miss_total_o,
                   want.evicts, evict_total_o);
        end
      end
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      opcode_i   <= '0;
      address_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_access(access_t'{opcode_i, address_i});
        n_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          next_word = pending_q.pop_front();
          in_valid_i <= 1'b1;
          opcode_i   <= next_word.opcode;
          address_i  <= next_word.address;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      if (hold_done != hold_ask) begin
        hold_done = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < gap_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_SET_INDEX_BITS:    cfg_m.set_index_bits    = val[2:0];
      REG_BLOCK_OFFSET_BITS: cfg_m.block_offset_bits = val[5:0];
      REG_WAY_COUNT:         cfg_m.way_count         = val[3:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // unused upper data bits carry noise
  task automatic set_config(input int unsigned sb, input int unsigned off,
                            input int unsigned nw);
    write_reg(REG_SET_INDEX_BITS, CFG_W'(sb) | (CFG_W'($urandom) & 6'b111000));
    write_reg(REG_BLOCK_OFFSET_BITS, CFG_W'(off));
    write_reg(REG_WAY_COUNT, CFG_W'(nw) | (CFG_W'($urandom) & 6'b110000));
    n_configs++;
  endtask

  task automatic settle();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_access(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
    pending_q.push_back(access_t'{op, addr});
  endtask

  // addresses reuse a few sets and a small tag pool per phase, with some noise
  task automatic random_phase(input int unsigned sb, input int unsigned off,
                              input int unsigned nw, input int n, input int pct,
                              input logic hold);
    int unsigned      esb, ew, sh, ntag;
    int               k;
    logic [TAG_W-1:0] tags [16];
    logic [63:0]      sets [3];
    logic [63:0]      a, smask;
    gap_pct = pct;
    set_config(sb, off, nw);
    esb = (sb > MAX_SET_INDEX_BITS_DEF) ? MAX_SET_INDEX_BITS_DEF : sb;
    ew = (nw < 1) ? 1 : ((nw > MAX_WAYS_DEF) ? MAX_WAYS_DEF : nw);
    sh = off + esb;
    ntag = ew + 2;
    smask = (64'd1 << esb) - 64'd1;
    for (k = 0; k < 16; k++) tags[k] = $urandom;
    for (k = 0; k < 3; k++) sets[k] = {$urandom, $urandom} & smask;
    if (hold) hold_ask++;
    for (k = 0; k < n; k++) begin
      a = {$urandom, $urandom};
      if ($urandom_range(9) != 0) begin
        a &= ~(smask << off);
        a |= sets[$urandom_range(2)] << off;
        if (sh < 64) begin
          a &= ~(64'hFFFF_FFFF << sh);
          a |= 64'(tags[$urandom_range(ntag - 1)]) << sh;
        end
      end
      push_access(2'($urandom_range(3)), a);
    end
    settle();
  endtask

  initial begin
    for (int k = 0; k < LINES; k++) begin
      tag_m[k] = '0;
      age_m[k] = '0;
    end
    hits_m   = '0;
    misses_m = '0;
    evicts_m = '0;
    cfg_m.set_index_bits    = 3'd0;
    cfg_m.block_offset_bits = 6'd0;
    cfg_m.way_count         = 4'd1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: one set, one way
    push_access(OP_LOAD, '0);
    push_access(OP_STORE, '0);
    push_access(OP_MODIFY, '0);
    push_access(OP_LOAD, '1);
    push_access(OP_ODD, '1);
    push_access(OP_MODIFY, 64'h1_0000_0000);
    push_access(OP_LOAD, '0);
    settle();

    // saturated index bits and way count, shift past the address
    set_config(7, 63, 15);
    push_access(OP_LOAD, 64'h8000_0000_0000_0000);
    push_access(OP_STORE, '1);
    push_access(OP_MODIFY, '0);
    settle();

    // same tag left in two ways, then seen again with both in use
    set_config(0, 0, 2);
    push_access(OP_LOAD, 64'hA);
    settle();
    set_config(0, 0, 1);
    push_access(OP_LOAD, 64'hA);
    settle();
    set_config(0, 0, 2);
    push_access(OP_LOAD, 64'hA);
    push_access(OP_STORE, 64'hB);
    settle();

    // zero ways behaves as one
    set_config(0, 0, 0);
    push_access(OP_LOAD, 64'h5);
    push_access(OP_ODD, 64'hA);
    settle();

    random_phase(2, 4, 4, 200, 19, 1'b0);
    random_phase(6, 6, 8, 250, 0, 1'b0);
    random_phase(0, 0, 1, 150, 19, 1'b0);
    random_phase(7, 63, 15, 150, 19, 1'b0);
    random_phase(3, 58, 2, 150, 19, 1'b0);
    random_phase(1, 48, 3, 200, 19, 1'b0);
    random_phase(4, 0, 0, 150, 19, 1'b0);
    random_phase(5, 10, 9, 200, 19, 1'b0);
    random_phase(6, 2, 8, 300, 19, 1'b1);

    $display("Ran %0d accesses (%0d modifies) over %0d register settings.", n_sent,
             n_modify, n_configs);
    $display("Saw %0d hits, %0d fills, %0d evictions; %0d words checked, %0d mismatches.",
             n_hit_out, n_fill, n_evict, n_checked, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
